>>> hw/rtl/bsc_pkg.sv
// ----------------------------------------------------------------------------
// bsc_pkg
// Shared types and constants for the battery state-of-charge conditioner.
// ----------------------------------------------------------------------------
package bsc_pkg;

   // request codes
   localparam logic [1:0] REQ_SCALED  = 2'd0;
   localparam logic [1:0] REQ_RAW     = 2'd1;
   localparam logic [1:0] REQ_RESCALE = 2'd2;
   localparam logic [1:0] REQ_RESUME  = 2'd3;

   // configuration register indexes
   localparam int unsigned CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] CSR_EMPTY_LEVEL  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_NOMINAL_FULL = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_FULL_MARGIN  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SCALE_EN     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_DYN_SCALE_EN = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_STEP_EN      = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_GUARD_EN     = 3'd6;
   localparam int unsigned CSR_DATA_W = 10;

   // field widths
   localparam int unsigned SOC_W   = 14;
   localparam int unsigned PCT_W   = 7;
   localparam int unsigned FS_W    = 11;
   localparam int unsigned EMPTY_W = 10;
   localparam int unsigned NOM_W   = 10;
   localparam int unsigned MARG_W  = 8;

   // divider geometry
   localparam int unsigned DIV_NUM_W = 21;
   localparam int unsigned DIV_DEN_W = 12;
   localparam int unsigned DIV_STEPS = DIV_NUM_W;
   localparam int unsigned DIV_CNT_W = 5;

   // arithmetic constants
   localparam logic [PCT_W-1:0]     PCT_MAX     = 7'd100;
   localparam logic [PCT_W-1:0]     PCT_SCALE   = 7'd100;
   localparam logic [PCT_W-1:0]     FS_MUL      = 7'd99;
   localparam logic [DIV_DEN_W-1:0] DEN_TEN     = 12'd10;
   localparam logic [DIV_DEN_W-1:0] DEN_HUNDRED = 12'd100;

   // reset values
   localparam logic [NOM_W-1:0]  NOMINAL_RST = 10'd990;
   localparam logic [MARG_W-1:0] MARGIN_RST  = 8'd50;

   typedef struct packed {
      logic [1:0]       req_type;
      logic [SOC_W-1:0] soc_value;
      logic             charging;
   } bsc_req_type;

   typedef struct packed {
      logic [SOC_W-1:0] result_value;
      logic             held_abnormal;
   } bsc_rsp_type;

   // controller to datapath
   typedef struct packed {
      logic capture;
      logic load;
      logic second;
      logic step;
      logic commit;
   } bsc_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic dyn_rescale;
      logic out_free;
   } bsc_sts_type;

endpackage

>>> hw/rtl/bsc_ctrl.sv
// ----------------------------------------------------------------------------
// bsc_ctrl
// Sequencer: captures a request, runs one or two divider passes, then commits
// the result into the output register.
// ----------------------------------------------------------------------------
module bsc_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  bsc_pkg::bsc_sts_type sts,
   output bsc_pkg::bsc_cmd_type cmd
);
   import bsc_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_LOAD = 4'b0010,
      ST_DIV  = 4'b0100,
      ST_DONE = 4'b1000
   } state_type;

   state_type            state_ff, state_in;
   logic                 pass_ff, pass_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 cnt_last;

   assign cnt_last = (cnt_ff == DIV_CNT_W'(DIV_STEPS - 1));

   // next state and commands
   always_comb begin
      state_in  = state_ff;
      pass_in   = pass_ff;
      cnt_in    = cnt_ff;
      req_ready = 1'b0;
      cmd       = '0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               pass_in     = 1'b0;
               state_in    = ST_LOAD;
            end
         end
         ST_LOAD: begin
            cmd.load   = 1'b1;
            cmd.second = pass_ff;
            cnt_in     = '0;
            state_in   = ST_DIV;
         end
         ST_DIV: begin
            cmd.step = 1'b1;
            cnt_in   = cnt_ff + 1'b1;
            if (cnt_last) begin
               if (!pass_ff && sts.dyn_rescale) begin
                  pass_in  = 1'b1;
                  state_in = ST_LOAD;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_DONE: begin
            if (sts.out_free) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         pass_ff  <= 1'b0;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         pass_ff  <= pass_in;
         cnt_ff   <= cnt_in;
      end
   end

endmodule

>>> hw/rtl/bsc_datapath.sv
// ----------------------------------------------------------------------------
// bsc_datapath
// Configuration and state registers, restoring divider, percent post-processing
// and the output register.
// ----------------------------------------------------------------------------
module bsc_datapath (
   input  logic                           clock,
   input  logic                           reset,
   input  bsc_pkg::bsc_cmd_type           cmd,
   output bsc_pkg::bsc_sts_type           sts,
   input  bsc_pkg::bsc_req_type           req_data,
   input  logic                           csr_we,
   input  logic [bsc_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [bsc_pkg::CSR_DATA_W-1:0] csr_wdata,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output bsc_pkg::bsc_rsp_type           rsp_data
);
   import bsc_pkg::*;

   // configuration
   logic signed [EMPTY_W-1:0] empty_ff, empty_in;
   logic [NOM_W-1:0]          nominal_ff, nominal_in;
   logic [MARG_W-1:0]         margin_ff, margin_in;
   logic                      scale_en_ff, scale_en_in;
   logic                      dyn_en_ff, dyn_en_in;
   logic                      step_en_ff, step_en_in;
   logic                      guard_en_ff, guard_en_in;

   // architectural state
   logic [PCT_W-1:0]          last_pct_ff, last_pct_in;
   logic                      resync_ff, resync_in;
   logic [FS_W-1:0]           full_scale_ff, full_scale_in;

   // captured request and divider
   bsc_req_type               item_ff;
   logic [DIV_NUM_W-1:0]      num_ff, num_in;
   logic [DIV_DEN_W-1:0]      rem_ff, rem_in;
   logic [DIV_DEN_W-1:0]      den_ff, den_in;

   // output register
   logic                      out_valid_ff, out_valid_in;
   bsc_rsp_type               out_data_ff, out_data_in;

   logic                      scale_on;
   logic signed [15:0]        diff;
   logic                      below_empty;
   logic signed [12:0]        span;
   logic                      span_bad;
   logic [21:0]               num_scaled;
   logic [FS_W-1:0]           raw;
   logic signed [11:0]        lo;
   logic [FS_W-1:0]           hi;
   logic [FS_W-1:0]           fs;
   logic [17:0]               fs99;
   logic [DIV_DEN_W:0]        trial;
   logic [DIV_DEN_W:0]        trial_sub;
   logic                      trial_ge;
   logic [PCT_W-1:0]          q_pct;
   logic [PCT_W-1:0]          p_calc;
   logic [PCT_W-1:0]          p_step;
   logic [PCT_W-1:0]          p_final;
   logic                      held;

   assign scale_on    = scale_en_ff | dyn_en_ff;

   // scaled read operands
   assign diff        = $signed({2'b00, item_ff.soc_value})
                        - $signed({{6{empty_ff[EMPTY_W-1]}}, empty_ff});
   assign below_empty = diff[15];
   assign span        = $signed({2'b00, full_scale_ff})
                        - $signed({{3{empty_ff[EMPTY_W-1]}}, empty_ff});
   assign span_bad    = span[12] | (span == 13'sd0);
   assign num_scaled  = 22'(diff[14:0]) * 22'(PCT_SCALE);

   // full scale clamp on the first-pass quotient
   assign raw = num_ff[FS_W-1:0];
   assign lo  = $signed({2'b00, nominal_ff}) - $signed({4'b0000, margin_ff});
   assign hi  = FS_W'({1'b0, nominal_ff} + {3'b000, margin_ff});

   always_comb begin
      if ($signed({1'b0, raw}) < lo) begin
         fs = lo[FS_W-1:0];
      end else if (raw > hi) begin
         fs = hi;
      end else begin
         fs = raw;
      end
   end

   assign fs99 = 18'(fs) * 18'(FS_MUL);

   // one restoring divider step
   assign trial     = {rem_ff, num_ff[DIV_NUM_W-1]};
   assign trial_sub = trial - {1'b0, den_ff};
   assign trial_ge  = (trial >= {1'b0, den_ff});

   always_comb begin
      num_in = num_ff;
      rem_in = rem_ff;
      den_in = den_ff;
      if (cmd.load) begin
         rem_in = '0;
         if (cmd.second) begin
            num_in = DIV_NUM_W'(fs99);
            den_in = DEN_HUNDRED;
         end else if (item_ff.req_type == REQ_SCALED && scale_on) begin
            num_in = num_scaled[DIV_NUM_W-1:0];
            den_in = span[DIV_DEN_W-1:0];
         end else begin
            num_in = DIV_NUM_W'(item_ff.soc_value);
            den_in = DEN_TEN;
         end
      end else if (cmd.step) begin
         num_in = {num_ff[DIV_NUM_W-2:0], trial_ge};
         rem_in = trial_ge ? trial_sub[DIV_DEN_W-1:0] : trial[DIV_DEN_W-1:0];
      end
   end

   // percent from quotient, clamped to 100
   assign q_pct = ((|num_ff[DIV_NUM_W-1:PCT_W]) || (num_ff[PCT_W-1:0] > PCT_MAX))
                  ? PCT_MAX : num_ff[PCT_W-1:0];

   always_comb begin
      if (item_ff.req_type == REQ_SCALED && scale_on) begin
         if (below_empty) begin
            p_calc = '0;
         end else if (span_bad) begin
            p_calc = PCT_MAX;
         end else begin
            p_calc = q_pct;
         end
      end else begin
         p_calc = q_pct;
      end
   end

   // step limit and direction guard
   always_comb begin
      p_step = p_calc;
      if (step_en_ff) begin
         if (last_pct_ff < p_calc) begin
            p_step = last_pct_ff + 1'b1;
         end else if (last_pct_ff > p_calc) begin
            p_step = last_pct_ff - 1'b1;
         end
      end
      p_final = p_step;
      held    = 1'b0;
      if (resync_ff) begin
         p_final = p_calc;
      end else if (guard_en_ff && ((item_ff.charging && last_pct_ff > p_step) ||
                                   (!item_ff.charging && last_pct_ff < p_step))) begin
         p_final = last_pct_ff;
         held    = 1'b1;
      end
   end

   // state update, configuration writes and result
   always_comb begin
      empty_in      = empty_ff;
      nominal_in    = nominal_ff;
      margin_in     = margin_ff;
      scale_en_in   = scale_en_ff;
      dyn_en_in     = dyn_en_ff;
      step_en_in    = step_en_ff;
      guard_en_in   = guard_en_ff;
      last_pct_in   = last_pct_ff;
      resync_in     = resync_ff;
      full_scale_in = full_scale_ff;
      out_data_in   = out_data_ff;
      out_valid_in  = out_valid_ff & ~rsp_ready;

      if (csr_we) begin
         case (csr_index)
            CSR_EMPTY_LEVEL:  empty_in = $signed(csr_wdata[EMPTY_W-1:0]);
            CSR_NOMINAL_FULL: begin
               nominal_in    = csr_wdata[NOM_W-1:0];
               full_scale_in = FS_W'(csr_wdata[NOM_W-1:0]);
            end
            CSR_FULL_MARGIN:  margin_in   = csr_wdata[MARG_W-1:0];
            CSR_SCALE_EN:     scale_en_in = csr_wdata[0];
            CSR_DYN_SCALE_EN: dyn_en_in   = csr_wdata[0];
            CSR_STEP_EN:      step_en_in  = csr_wdata[0];
            CSR_GUARD_EN:     guard_en_in = csr_wdata[0];
            default: begin
            end
         endcase
      end

      if (cmd.commit) begin
         out_valid_in              = 1'b1;
         out_data_in.held_abnormal = 1'b0;
         case (item_ff.req_type)
            REQ_SCALED: begin
               last_pct_in               = p_final;
               resync_in                 = 1'b0;
               out_data_in.result_value  = SOC_W'(p_final);
               out_data_in.held_abnormal = held;
            end
            REQ_RAW: begin
               out_data_in.result_value = item_ff.soc_value;
            end
            REQ_RESCALE: begin
               if (dyn_en_ff) begin
                  full_scale_in            = num_ff[FS_W-1:0];
                  out_data_in.result_value = SOC_W'(num_ff[FS_W-1:0]);
               end else begin
                  out_data_in.result_value = SOC_W'(full_scale_ff);
               end
            end
            REQ_RESUME: begin
               resync_in                = 1'b1;
               out_data_in.result_value = '0;
            end
            default: begin
               out_data_in.result_value = '0;
            end
         endcase
      end
   end

   // control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         empty_ff      <= '0;
         nominal_ff    <= NOMINAL_RST;
         margin_ff     <= MARGIN_RST;
         scale_en_ff   <= 1'b0;
         dyn_en_ff     <= 1'b0;
         step_en_ff    <= 1'b0;
         guard_en_ff   <= 1'b0;
         last_pct_ff   <= '0;
         resync_ff     <= 1'b1;
         full_scale_ff <= FS_W'(NOMINAL_RST);
         out_valid_ff  <= 1'b0;
      end else begin
         empty_ff      <= empty_in;
         nominal_ff    <= nominal_in;
         margin_ff     <= margin_in;
         scale_en_ff   <= scale_en_in;
         dyn_en_ff     <= dyn_en_in;
         step_en_ff    <= step_en_in;
         guard_en_ff   <= guard_en_in;
         last_pct_ff   <= last_pct_in;
         resync_ff     <= resync_in;
         full_scale_ff <= full_scale_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         item_ff <= req_data;
      end
      num_ff      <= num_in;
      rem_ff      <= rem_in;
      den_ff      <= den_in;
      out_data_ff <= out_data_in;
   end

   assign sts.dyn_rescale = (item_ff.req_type == REQ_RESCALE) && dyn_en_ff;
   assign sts.out_free    = ~out_valid_ff | rsp_ready;
   assign rsp_valid       = out_valid_ff;
   assign rsp_data        = out_data_ff;

endmodule

>>> hw/rtl/battery_soc_conditioner.sv
// A request passes through load, divider steps and done before its result is committed;
// a rescale with dynamic scaling on runs a second load and divider pass first.
// One request at a time: the next request is taken once the previous one has been
// committed to the output register, later while a stalled result still occupies
// that register.
// Reset: synchronous, active high; config to defaults, full scale 990, resync set.
// ----------------------------------------------------------------------------
// battery_soc_conditioner
// Conditions gauge state-of-charge readings into a whole percent, with
// optional rescaling, step limiting and direction guard.
// ----------------------------------------------------------------------------
module battery_soc_conditioner (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  bsc_pkg::bsc_req_type           req_data,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output bsc_pkg::bsc_rsp_type           rsp_data,
   input  logic                           csr_we,
   input  logic [bsc_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [bsc_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import bsc_pkg::*;

   bsc_cmd_type cmd;
   bsc_sts_type sts;

   // sequencer
   bsc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // arithmetic and state
   bsc_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .sts       (sts),
      .req_data  (req_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

>>> hw/rtl/bsc_checker.sv
// ----------------------------------------------------------------------------
// bsc_checker
// Port-level checks for the battery state-of-charge conditioner.
// ----------------------------------------------------------------------------
module bsc_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_ready,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input bsc_pkg::bsc_rsp_type rsp_data
);
   import bsc_pkg::*;

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   // one request at a time: busy right after a transfer
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while busy");

   // a held reading is always a percent
   a_held_is_pct: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.held_abnormal |-> rsp_data.result_value <= SOC_W'(PCT_MAX))
      else $error("held reading out of percent range");

   // no result straight out of reset
   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind battery_soc_conditioner bsc_checker u_bsc_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

>>> tb/battery_soc_conditioner_tb.sv
// ----------------------------------------------------------------------------
// battery_soc_conditioner_tb
// Self-checking bench for the state-of-charge conditioner. A scoreboard
// class keeps its own copy of the registers and the conditioning state and
// predicts every result. Directed requests cover the clamps, the resync
// load, the step limit and the direction guard. Random phases with changing
// settings and changing idle patterns on both channels follow.
// ----------------------------------------------------------------------------
module battery_soc_conditioner_tb;
   import bsc_pkg::*;

   localparam int HOLD_CYCLES   = 300;
   localparam int ITEMS_PER_RUN = 50;
   localparam int RANDOM_PHASES = 13;
   localparam int TAIL_CYCLES   = 60;
   localparam int SOC_FULL      = 1000;

   // predicts conditioned readings and checks them in order
   class soc_checker;
      logic signed [EMPTY_W-1:0] empty_level;
      logic [NOM_W-1:0]          nominal_full;
      logic [MARG_W-1:0]         full_margin;
      logic                      scale_en;
      logic                      dyn_scale_en;
      logic                      step_en;
      logic                      guard_en;
      logic [PCT_W-1:0]          last_pct;
      logic                      resync_pending;
      logic [FS_W-1:0]           full_scale;
      bsc_rsp_type               expected_results[$];
      int                        failures;

      function new();
         empty_level    = '0;
         nominal_full   = NOMINAL_RST;
         full_margin    = MARGIN_RST;
         scale_en       = 1'b0;
         dyn_scale_en   = 1'b0;
         step_en        = 1'b0;
         guard_en       = 1'b0;
         last_pct       = '0;
         resync_pending = 1'b1;
         full_scale     = FS_W'(NOMINAL_RST);
         failures       = 0;
      endfunction

      function void write_register(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         case (idx)
            CSR_EMPTY_LEVEL: empty_level = data;
            CSR_NOMINAL_FULL: begin
               // nominal write also reloads the full scale
               nominal_full = data;
               full_scale   = FS_W'(data);
            end
            CSR_FULL_MARGIN:  full_margin  = data[MARG_W-1:0];
            CSR_SCALE_EN:     scale_en     = data[0];
            CSR_DYN_SCALE_EN: dyn_scale_en = data[0];
            CSR_STEP_EN:      step_en      = data[0];
            CSR_GUARD_EN:     guard_en     = data[0];
            default: ;
         endcase
      endfunction

      function bsc_rsp_type predict_soc_result(bsc_req_type r);
         bsc_rsp_type res;
         int          x;
         int          div;
         int          pct;
         int          prev;
         int          raw;
         int          lo;
         int          hi;
         int          fs;
         res = '0;
         case (r.req_type)
            REQ_SCALED: begin
               x = int'(r.soc_value);
               // linear rescale between empty level and full scale
               if (scale_en || dyn_scale_en) begin
                  div = int'(full_scale) - int'(empty_level);
                  if (x < int'(empty_level)) x = 0;
                  else if (div <= 0) x = SOC_FULL;
                  else x = (x - int'(empty_level)) * SOC_FULL / div;
               end
               if (x > SOC_FULL) x = SOC_FULL;
               if (x < 0) x = 0;
               pct  = x / 10;
               prev = int'(last_pct);
               if (resync_pending) begin
                  resync_pending = 1'b0;
               end else begin
                  if (step_en) begin
                     if (prev < pct) pct = prev + 1;
                     else if (prev > pct) pct = prev - 1;
                  end
                  // hold when moving against the charging direction
                  if (guard_en && ((r.charging && prev > pct) || (!r.charging && prev < pct))) begin
                     pct = prev;
                     res.held_abnormal = 1'b1;
                  end
               end
               last_pct = PCT_W'(pct);
               res.result_value = SOC_W'(pct);
            end
            REQ_RAW: res.result_value = r.soc_value;
            REQ_RESCALE: begin
               // full scale from a 0.01% reading, clamped around nominal
               if (dyn_scale_en) begin
                  raw = int'(r.soc_value) / 10;
                  lo  = int'(nominal_full) - int'(full_margin);
                  hi  = int'(nominal_full) + int'(full_margin);
                  if (raw < lo) fs = lo;
                  else if (raw > hi) fs = hi;
                  else fs = raw;
                  full_scale = FS_W'(fs * 99 / 100);
               end
               res.result_value = SOC_W'(full_scale);
            end
            default: begin
               resync_pending   = 1'b1;
               res.result_value = '0;
            end
         endcase
         return res;
      endfunction

      function void note_request(bsc_req_type r);
         expected_results.push_back(predict_soc_result(r));
      endfunction

      function void check_response(bsc_rsp_type got);
         bsc_rsp_type want;
         if (expected_results.size() == 0) begin
            $error("response with none expected: result_value %0d held_abnormal %0d",
                   got.result_value, got.held_abnormal);
            failures++;
            return;
         end
         want = expected_results.pop_front();
         if (got.result_value !== want.result_value) begin
            $error("result_value: expected %0d, actual %0d", want.result_value, got.result_value);
            failures++;
         end
         if (got.held_abnormal !== want.held_abnormal) begin
            $error("held_abnormal: expected %0d, actual %0d",
                   want.held_abnormal, got.held_abnormal);
            failures++;
         end
      endfunction

      function int outstanding();
         return expected_results.size();
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   bsc_req_type           req_data = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   bsc_rsp_type           rsp_data;
   logic                  csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = CSR_EMPTY_LEVEL;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   soc_checker sb = new();

   int   send_idle_pct  = 0;
   int   recv_stall_pct = 0;
   logic hold_token     = 1'b0;
   logic hold_seen;
   int   hold_left;
   int   gauge_walk     = 500;

   battery_soc_conditioner dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // clock
   initial begin
      forever #1 clock = ~clock;
   end

   // run limit
   initial begin
      #2000000;
      $display("Test completed with failures");
      $finish;
   end

   // receiver: random stalls, plus a long hold-off on each token toggle
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         hold_left <= 0;
         hold_seen <= 1'b0;
      end else if (hold_token != hold_seen) begin
         hold_seen <= hold_token;
         hold_left <= HOLD_CYCLES;
         rsp_ready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // result transfers
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) sb.check_response(rsp_data);
   end

   function bsc_req_type make_request(logic [1:0] kind, int value, logic chg);
      bsc_req_type r;
      r.req_type  = kind;
      r.soc_value = SOC_W'(value);
      r.charging  = chg;
      return r;
   endfunction

   // mostly a slow gauge walk around the interesting range, some full-range noise
   function bsc_req_type random_request();
      bsc_req_type r;
      int          pick;
      pick       = $urandom_range(99);
      r.charging = 1'($urandom_range(1));
      r.soc_value = SOC_W'($urandom_range(16383));
      if (pick < 62) begin
         r.req_type = REQ_SCALED;
         if ($urandom_range(99) < 80) begin
            gauge_walk = gauge_walk + int'($urandom_range(60)) - 30;
            if (gauge_walk < 0) gauge_walk = 0;
            if (gauge_walk > 1300) gauge_walk = 1300;
            r.soc_value = SOC_W'(gauge_walk);
         end
      end else if (pick < 77) begin
         r.req_type = REQ_RAW;
      end else if (pick < 90) begin
         r.req_type = REQ_RESCALE;
         if ($urandom_range(1)) r.soc_value = SOC_W'($urandom_range(13000, 6000));
      end else begin
         r.req_type = REQ_RESUME;
      end
      return r;
   endfunction

   // one request transfer; valid drops only for an idle gap
   task send_request(bsc_req_type r);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (!req_ready);
      sb.note_request(r);
   endtask

   task wait_results_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (sb.outstanding() != 0);
   endtask

   task write_csr(logic [CSR_IDX_W-1:0] idx, int value);
      logic [CSR_DATA_W-1:0] bits;
      bits = CSR_DATA_W'(value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= bits;
      @(posedge clock);
      sb.write_register(idx, bits);
   endtask

   // full register set; only called with nothing in flight
   task program_config(int empty, int nominal, int margin, bit se, bit dse, bit ste, bit ge,
                       bit reload_nominal);
      write_csr(CSR_EMPTY_LEVEL, empty);
      if (reload_nominal) write_csr(CSR_NOMINAL_FULL, nominal);
      write_csr(CSR_FULL_MARGIN, margin);
      write_csr(CSR_SCALE_EN, se);
      write_csr(CSR_DYN_SCALE_EN, dse);
      write_csr(CSR_STEP_EN, ste);
      write_csr(CSR_GUARD_EN, ge);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   initial begin
      int mode;

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // defaults: resync load, clamp at full, raw extremes, rescale while disabled
      send_request(make_request(REQ_SCALED, 0, 1'b0));
      send_request(make_request(REQ_SCALED, 16383, 1'b1));
      send_request(make_request(REQ_RAW, 16383, 1'b0));
      send_request(make_request(REQ_RAW, 0, 1'b1));
      send_request(make_request(REQ_RESCALE, 16383, 1'b0));
      send_request(make_request(REQ_RESUME, 0, 1'b0));
      send_request(make_request(REQ_SCALED, 500, 1'b0));

      // widest margin: rescale clamps, step limit and direction guard
      wait_results_drained();
      program_config(-200, 1000, 200, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1);
      send_request(make_request(REQ_RESCALE, 16383, 1'b0));
      send_request(make_request(REQ_RESCALE, 0, 1'b1));
      send_request(make_request(REQ_SCALED, 0, 1'b0));
      send_request(make_request(REQ_SCALED, 0, 1'b1));
      send_request(make_request(REQ_SCALED, 16383, 1'b1));
      send_request(make_request(REQ_SCALED, 16383, 1'b0));
      send_request(make_request(REQ_RESUME, 16383, 1'b1));
      send_request(make_request(REQ_SCALED, 16383, 1'b0));

      // negative divisor and reading below empty
      wait_results_drained();
      program_config(500, 400, 0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1);
      send_request(make_request(REQ_SCALED, 600, 1'b0));
      send_request(make_request(REQ_SCALED, 100, 1'b1));
      send_request(make_request(REQ_SCALED, 16383, 1'b0));

      // lower clamp below zero, zero divisor, alternating raw bit patterns
      wait_results_drained();
      program_config(0, 100, 200, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1);
      send_request(make_request(REQ_RESCALE, 0, 1'b0));
      send_request(make_request(REQ_SCALED, 300, 1'b1));
      send_request(make_request(REQ_RAW, 'h2AAA, 1'b0));
      send_request(make_request(REQ_RAW, 'h1555, 1'b1));
      send_request(make_request(REQ_RESCALE, 9999, 1'b0));
      send_request(make_request(REQ_SCALED, 150, 1'b0));

      // random phases with new settings and idle patterns
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         wait_results_drained();
         case (phase)
            0: program_config(-200, 1000, 200, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1);
            1: program_config(500, 0, 0, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1);
            2: program_config(0, 990, 50, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1);
            default: program_config(int'($urandom_range(700)) - 200,
                                    int'($urandom_range(1000)), int'($urandom_range(200)),
                                    1'($urandom_range(1)), 1'($urandom_range(1)),
                                    1'($urandom_range(1)), 1'($urandom_range(1)),
                                    1'($urandom_range(1)));
         endcase
         mode = phase % 4;
         send_idle_pct   = (mode == 1) ? 84 : (mode == 3) ? 13 : 0;
         recv_stall_pct <= (mode == 2) ? 84 : (mode == 3) ? 13 : 0;
         // long receiver hold-off while requests keep coming
         if (phase == 4 || phase == 9) hold_token <= ~hold_token;
         repeat (ITEMS_PER_RUN) send_request(random_request());
      end

      wait_results_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (sb.failures == 0 && sb.outstanding() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
